// ===== src/dmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants of the direct-mapped cache tag unit: field
// split, transfer payloads, controller states and control/status groups.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam int unsigned NUM_LINES   = 128;
  localparam int unsigned BLOCK_BYTES = 32;

  localparam int unsigned OFF_BITS  = $clog2(BLOCK_BYTES);
  localparam int unsigned IDX_BITS  = $clog2(NUM_LINES);
  localparam int unsigned ADDR_BITS = 32;
  localparam int unsigned BLK_BITS  = ADDR_BITS - OFF_BITS;
  localparam int unsigned TAG_BITS  = ADDR_BITS - OFF_BITS - IDX_BITS;
  localparam int unsigned SIZE_BITS = 6;

  localparam logic [SIZE_BITS-1:0] FILL_SIZE = SIZE_BITS'(BLOCK_BYTES);

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [ADDR_BITS-1:0] address;
    logic                 opcode;
  } req_t;

  typedef struct packed {
    logic [OFF_BITS-1:0]  byte_offset;
    logic [BLK_BITS-1:0]  block_number;
    logic [IDX_BITS-1:0]  line_index;
    logic [TAG_BITS-1:0]  addr_tag;
    logic                 miss;
    logic                 mem_read;
    logic [SIZE_BITS-1:0] mem_read_size;
    logic                 mem_write;
    logic                 mem_write_size;
    logic                 replaced;
    logic [TAG_BITS-1:0]  evicted_tag;
  } rsp_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_LOOKUP = 1'b1
  } state_e;

  typedef struct packed {
    logic capture;
    logic lookup;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } status_t;

endpackage

// ===== src/dmc_ram.sv =====
// ----------------------------------------------------------------------------
// dmc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/dmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmc_ctrl
// Controller: takes a request transfer, then runs the tag lookup once the
// result register has room.
// ----------------------------------------------------------------------------
module dmc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  dmc_pkg::status_t status_i,
  output dmc_pkg::cmd_t    cmd_o
);
  import dmc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (status_i.slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o     = 1'b1;
    cmd_o.capture  = 1'b0;
    cmd_o.lookup   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_LOOKUP: begin
        cmd_o.lookup = status_i.slot_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/dmc_dp.sv =====
// ----------------------------------------------------------------------------
// dmc_dp
// Datapath: request register, tag RAM, valid bits, hit/miss logic and the
// result register.
// ----------------------------------------------------------------------------
module dmc_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dmc_pkg::req_t    in_data_i,
  input  dmc_pkg::cmd_t    cmd_i,
  output dmc_pkg::status_t status_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dmc_pkg::rsp_t    out_data_o
);
  import dmc_pkg::*;

  logic [ADDR_BITS-1:0] addr_q;
  logic                 op_q;
  logic [NUM_LINES-1:0] valid_q, valid_d;
  logic                 out_valid_q, out_valid_d;
  rsp_t                 rsp_q, rsp_d;

  logic [IDX_BITS-1:0]  rd_idx;
  logic [IDX_BITS-1:0]  idx;
  logic [TAG_BITS-1:0]  tag;
  logic [TAG_BITS-1:0]  stored_tag;
  logic                 was_valid;
  logic                 miss;
  logic                 rd_miss;
  logic                 repl;
  logic                 is_write;
  logic                 fill;

  assign rd_idx = in_data_i.address[OFF_BITS +: IDX_BITS];
  assign idx    = addr_q[OFF_BITS +: IDX_BITS];
  assign tag    = addr_q[ADDR_BITS-1 -: TAG_BITS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q <= in_data_i.address;
      op_q   <= in_data_i.opcode;
    end
  end

  assign is_write = (op_q == OP_WRITE);
  assign fill     = cmd_i.lookup && !is_write;

  dmc_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (NUM_LINES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (fill),
    .waddr_i (idx),
    .wdata_i (tag),
    .re_i    (cmd_i.capture),
    .raddr_i (rd_idx),
    .rdata_o (stored_tag)
  );

  assign was_valid = valid_q[idx];
  assign miss      = !was_valid || (stored_tag != tag);
  assign rd_miss   = !is_write && miss;
  assign repl      = rd_miss && was_valid;

  always_comb begin
    valid_d = valid_q;
    if (fill) valid_d[idx] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_comb begin
    rsp_d.byte_offset    = addr_q[OFF_BITS-1:0];
    rsp_d.block_number   = addr_q[ADDR_BITS-1:OFF_BITS];
    rsp_d.line_index     = idx;
    rsp_d.addr_tag       = tag;
    rsp_d.miss           = miss;
    rsp_d.mem_read       = rd_miss;
    rsp_d.mem_read_size  = rd_miss ? FILL_SIZE : '0;
    rsp_d.mem_write      = is_write;
    rsp_d.mem_write_size = is_write;
    rsp_d.replaced       = repl;
    rsp_d.evicted_tag    = repl ? stored_tag : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) rsp_q <= rsp_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.lookup) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.slot_free = !out_valid_q || !out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = rsp_q;

  a_lookup_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lookup |-> (!out_valid_q || !out_stall_i))
    else $error("lookup issued while result register is full");

  a_lookup_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lookup |=> out_valid_q)
    else $error("lookup result not presented");

  a_fill_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill |=> valid_q[$past(idx)])
    else $error("read did not set the line valid bit");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.capture && cmd_i.lookup))
    else $error("capture and lookup in the same cycle");

endmodule

// ===== src/direct_mapped_cache_tag_unit.sv =====
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_unit
// Tag unit of a direct-mapped, write-through, no-write-allocate cache.
//
//   channel  dir  handshake               payload
//   request  in   in_valid_i / in_stall_o  in_data_i  (dmc_pkg::req_t)
//   result   out  out_valid_o/ out_stall_i out_data_o (dmc_pkg::rsp_t)
//
// A request is first captured while the tag RAM is read (registered read
// port); then the tags are compared, the line is updated and the result
// register is loaded. A request is taken while a result waits downstream;
// the lookup waits until the result register has room. Reset clears all
// valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module direct_mapped_cache_tag_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dmc_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dmc_pkg::rsp_t out_data_o
);
  import dmc_pkg::*;

  cmd_t    cmd;
  status_t status;

  dmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dmc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
